FILE: hw/rtl/y2r_pkg.sv
// shared types, constant tables and helpers of the 4:2:0 block to rgb converter
package y2r_pkg;

  // width of one table entry and of the per-pixel sums
  localparam int unsigned RomW = 23;
  localparam int unsigned GuvW = RomW + 1;
  localparam int unsigned SumW = RomW + 2;

  // scaled coefficients, times 1000 * 2^13
  localparam longint CoefY  = 64'd9535988;
  localparam longint CoefRv = 64'd13074932;
  localparam longint CoefGu = 64'd3203572;
  localparam longint CoefGv = 64'd6660596;
  localparam longint CoefBu = 64'd16531956;
  localparam longint BiasY  = 64'd16;
  localparam longint BiasC  = 64'd128;

  // position of the last pixel of a block
  localparam logic [1:0] PosLast = 2'd3;

  typedef logic [255:0][RomW-1:0] rom_t;

  typedef enum logic [1:0] {
    MODE_XRGB = 2'd0,
    MODE_RGB  = 2'd1,
    MODE_MASK = 2'd2
  } mode_e;

  // one queued block: luma and mask luma samples, chroma terms and the output mode
  typedef struct packed {
    mode_e                   mode;
    logic [3:0][7:0]         luma;
    logic [3:0][7:0]         mask_luma;
    logic signed [RomW-1:0]  rv;
    logic signed [GuvW-1:0]  guv;
    logic signed [RomW-1:0]  bu;
    logic signed [RomW-1:0]  mrv;
  } cmd_t;

  // table build, evaluated at elaboration only
  function automatic rom_t build_rom(longint coef, longint bias);
    rom_t   r;
    longint k;
    longint v;
    for (int i = 0; i < 256; i++) begin
      k    = longint'(i) - bias;
      v    = (coef * k) / 1000;
      r[i] = v[RomW-1:0];
    end
    return r;
  endfunction

  localparam rom_t YtRom = build_rom(CoefY, BiasY);
  localparam rom_t RvRom = build_rom(CoefRv, BiasC);
  localparam rom_t GuRom = build_rom(CoefGu, BiasC);
  localparam rom_t GvRom = build_rom(CoefGv, BiasC);
  localparam rom_t BuRom = build_rom(CoefBu, BiasC);

  // floor shift by 13 and clamp to 0..255
  function automatic logic [7:0] shift_clamp(logic signed [SumW-1:0] s);
    logic signed [SumW-14:0] q;
    logic [7:0]              r;
    q = s[SumW-1:13];
    if (q < 0) begin
      r = 8'd0;
    end else if (q > (SumW-13)'(255)) begin
      r = 8'd255;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/y2r_front.sv
// front end: mode register, block intake and chroma table lookups
module y2r_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [87:0]       s_axis_tdata_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output y2r_pkg::cmd_t     push_cmd_o
);

  logic [1:0] mode_q, mode_d;
  logic       mode_ok;
  logic [7:0] cb, cr, mcr;
  logic signed [y2r_pkg::RomW-1:0] gu, gv;

  // mode register, written over its own channel
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mode_d = mode_q;
    if (cfg_valid_i) begin
      mode_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // the unused mode code drops the block without results
  assign mode_ok = (mode_q == y2r_pkg::MODE_XRGB) || (mode_q == y2r_pkg::MODE_RGB) ||
                   (mode_q == y2r_pkg::MODE_MASK);

  assign s_axis_tready_o = push_ready_i;
  assign push_valid_o    = s_axis_tvalid_i && mode_ok;

  // chroma fields
  assign cb  = s_axis_tdata_i[39:32];
  assign cr  = s_axis_tdata_i[47:40];
  assign mcr = s_axis_tdata_i[87:80];
  assign gu  = $signed(y2r_pkg::GuRom[cb]);
  assign gv  = $signed(y2r_pkg::GvRom[cr]);

  // queue entry: chroma terms are shared by all four pixels
  always_comb begin
    push_cmd_o.mode      = y2r_pkg::mode_e'(mode_q);
    push_cmd_o.luma      = s_axis_tdata_i[31:0];
    push_cmd_o.mask_luma = s_axis_tdata_i[79:48];
    push_cmd_o.rv        = $signed(y2r_pkg::RvRom[cr]);
    push_cmd_o.guv       = y2r_pkg::GuvW'(gu) + y2r_pkg::GuvW'(gv);
    push_cmd_o.bu        = $signed(y2r_pkg::BuRom[cb]);
    push_cmd_o.mrv       = $signed(y2r_pkg::RvRom[mcr]);
  end

endmodule

FILE: hw/rtl/y2r_queue.sv
// short block queue between front end and pixel back end
module y2r_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  y2r_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output y2r_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  y2r_pkg::cmd_t        mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: hw/rtl/y2r_back.sv
// back end: one pixel per cycle unless stalled, registered output
module y2r_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  y2r_pkg::cmd_t pop_cmd_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [31:0]   m_axis_tdata_o,
  output logic [1:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o
);

  logic [1:0]  pix_q, pix_d;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic [31:0] data_q;
  logic [1:0]  pos_q;
  logic        last_q;
  logic [7:0]  red, green, blue, alpha;
  logic signed [y2r_pkg::RomW-1:0] y_term, my_term;
  logic signed [y2r_pkg::SumW-1:0] r_sum, g_sum, b_sum, a_sum;

  // a pixel moves when the output register is free or being drained
  assign advance     = pop_valid_i && (!out_valid_q || m_axis_tready_i);
  assign pop_ready_o = advance && (pix_q == y2r_pkg::PosLast);

  // luma lookups for the current pixel
  assign y_term  = $signed(y2r_pkg::YtRom[pop_cmd_i.luma[pix_q]]);
  assign my_term = $signed(y2r_pkg::YtRom[pop_cmd_i.mask_luma[pix_q]]);

  // channel sums
  assign r_sum = y2r_pkg::SumW'(y_term) + y2r_pkg::SumW'(pop_cmd_i.rv);
  assign g_sum = y2r_pkg::SumW'(y_term) - y2r_pkg::SumW'(pop_cmd_i.guv);
  assign b_sum = y2r_pkg::SumW'(y_term) + y2r_pkg::SumW'(pop_cmd_i.bu);
  assign a_sum = y2r_pkg::SumW'(my_term) + y2r_pkg::SumW'(pop_cmd_i.mrv);

  assign red   = y2r_pkg::shift_clamp(r_sum);
  assign green = y2r_pkg::shift_clamp(g_sum);
  assign blue  = y2r_pkg::shift_clamp(b_sum);

  // alpha by mode
  always_comb begin
    unique case (pop_cmd_i.mode)
      y2r_pkg::MODE_XRGB: alpha = 8'd255;
      y2r_pkg::MODE_RGB:  alpha = 8'd0;
      y2r_pkg::MODE_MASK: alpha = y2r_pkg::shift_clamp(a_sum);
      default:            alpha = 8'd0;
    endcase
  end

  // pixel counter and output valid
  always_comb begin
    pix_d       = pix_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      pix_d       = pix_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pix_q       <= pix_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      data_q <= {alpha, blue, green, red};
      pos_q  <= pix_q;
      last_q <= (pix_q == y2r_pkg::PosLast);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = pos_q;
  assign m_axis_tlast_o  = last_q;

  // last flag marks exactly the bottom right pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == y2r_pkg::PosLast)))
    else $error("tlast does not match pixel position");

  // a block leaves the queue only with its fourth pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_i && pop_ready_o) |-> (pix_q == y2r_pkg::PosLast))
    else $error("block popped before its last pixel");

  // each emitted pixel carries the counter value it was built from
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (pos_q == $past(pix_q)) && (pix_q == $past(pix_q) + 2'd1)))
    else $error("pixel counter and output position out of step");

  // stalled output keeps its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(pos_q) && $stable(data_q)))
    else $error("stalled pixel changed");

endmodule

FILE: hw/rtl/yuv420_block_to_rgb_unit.sv
// top level of the 4:2:0 block to rgb converter
//
// usage:
//   s_axis carries one 2x2 block per transfer (four luma samples, shared cb and
//   cr, and the paired alpha block's four luma samples and cr). m_axis gives
//   four pixels per block in the order top left, top right, bottom left,
//   bottom right; tuser holds the pixel position and tlast flags the fourth.
//   cfg sets the output mode: xrgb with alpha 255, rgb with alpha 0, or alpha
//   from the paired block. with the unused mode code blocks are taken and
//   dropped. write cfg only while no block is in flight.
// timing:
//   the first pixel of a block passes the queue entry and the output register;
//   the others follow one per cycle while the output is not stalled. one pixel
//   datapath is shared by the four pixels; a block leaves with its fourth.
//   a small block queue sits between intake and the pixel datapath, so intake
//   keeps going while the output stalls until the queue is full.
// reset:
//   mode returns to xrgb, queue and output register empty; no clearing pass.
module yuv420_block_to_rgb_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,       // output_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red, mask_luma_top_left, mask_luma_top_right,
  // mask_luma_bottom_left, mask_luma_bottom_right, mask_chroma_red
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,     // red, green, blue, alpha
  output logic [1:0]  m_axis_tuser,     // pixel_position
  output logic        m_axis_tlast      // last_pixel
);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  y2r_pkg::cmd_t push_cmd, pop_cmd;

  // intake and chroma lookups
  y2r_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  // block queue
  y2r_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // pixel datapath
  y2r_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_cmd_i       (pop_cmd),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

endmodule
